>>> hw/rtl/proportional_three_stream_split_assert.svh
// Assertion macros shared by the splitter RTL.
`ifndef PROPORTIONAL_THREE_STREAM_SPLIT_ASSERT_SVH
`define PROPORTIONAL_THREE_STREAM_SPLIT_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define PTSS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define PTSS_ASSERT_IMPLY(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/ptss_pkg.sv
// ----------------------------------------------------------------------------
// Proportional three-stream split package
// Shared constants: default length width, channel codes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptss_pkg;

  localparam int unsigned DEFAULT_LENGTH_BITS = 24;
  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned CFG_IDX_W           = 2;
  localparam int unsigned CHAN_W              = 2;

  localparam logic [CHAN_W-1:0] CH_LUMA = 2'd0;
  localparam logic [CHAN_W-1:0] CH_CB   = 2'd1;
  localparam logic [CHAN_W-1:0] CH_CR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LUMA_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CB_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CR_SIZE   = 2'd2;

endpackage

`default_nettype wire

>>> hw/rtl/proportional_three_stream_split.sv
// ----------------------------------------------------------------------------
// Proportional three-stream split
// Routes an interleaved byte stream to luma, Cb and Cr in proportional runs.
// ----------------------------------------------------------------------------
// The first request of a stream (after reset, after a register write or after
// a request marked buffer_end) runs the setup: the smallest size m is found and
// each size is divided by m on one shared restoring divider, one quotient bit
// per cycle, in DIV_LOAD and DIV_STEP; START then opens the first share.
// Each request is then accepted in IDLE and routed in ROUTE, which waits while
// out_stall_i holds the output register; no new request is taken meanwhile. A
// request is dropped with no result when any size is zero at stream start, and
// after the schedule of m packages has finished until a request marked buffer_end.
`timescale 1ns / 1ps
`default_nettype none

module proportional_three_stream_split #(
  parameter int unsigned LENGTH_BITS = ptss_pkg::DEFAULT_LENGTH_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ptss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LENGTH_BITS-1:0]         cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [ptss_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic                           buffer_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [ptss_pkg::BYTE_W-1:0]         out_byte_o,
  output logic [ptss_pkg::CHAN_W-1:0]         channel_o,
  output logic [LENGTH_BITS-1:0]              luma_routed_o,
  output logic [LENGTH_BITS-1:0]              cb_routed_o,
  output logic [LENGTH_BITS-1:0]              cr_routed_o,
  output logic                                stream_done_o
);

  import ptss_pkg::*;

  `include "proportional_three_stream_split_assert.svh"

  localparam int unsigned CntW = $clog2(LENGTH_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_START,
    ST_ROUTE
  } state_e;

  typedef logic [LENGTH_BITS-1:0] len_t;

  state_e               state_q;
  len_t                 size_q [3];
  len_t                 base_q [3];
  len_t                 frac_q [3];
  len_t                 carry_q [3];
  len_t                 count_q [3];
  len_t                 m_q;
  len_t                 packages_q;
  len_t                 left_q;
  logic [CHAN_W-1:0]    cur_ch_q;
  logic                 started_q;
  logic                 finished_q;
  logic [BYTE_W-1:0]    byte_q;
  logic                 last_q;
  logic [CHAN_W-1:0]    div_ch_q;
  logic [CntW-1:0]      cnt_q;
  len_t                 rem_q;
  len_t                 quo_q;
  logic                 out_valid_q;
  logic [BYTE_W-1:0]    out_byte_q;
  logic [CHAN_W-1:0]    out_ch_q;
  len_t                 out_count_q [3];
  logic                 out_done_q;

  logic                 in_accept;
  logic                 out_free;
  logic                 any_zero;
  len_t                 min_01;
  len_t                 min_size;

  logic [LENGTH_BITS:0] rem_shift;
  logic [LENGTH_BITS:0] rem_diff;
  logic                 quo_bit;
  len_t                 rem_next;
  len_t                 quo_next;

  logic [CHAN_W-1:0]    ent_ch;
  len_t                 ent_carry_in;
  logic [LENGTH_BITS:0] ent_acc;
  logic                 ent_ge;
  len_t                 ent_left;
  len_t                 ent_carry;

  len_t                 left_dec;
  logic                 share_end;
  len_t                 pkg_next;
  logic                 pkg_last;
  len_t                 cnt_inc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign any_zero = (size_q[CH_LUMA] == '0) || (size_q[CH_CB] == '0) || (size_q[CH_CR] == '0);
  assign min_01   = (size_q[CH_CB] < size_q[CH_LUMA]) ? size_q[CH_CB] : size_q[CH_LUMA];
  assign min_size = (size_q[CH_CR] < min_01) ? size_q[CH_CR] : min_01;

  // One restoring divider step: shift in the next dividend bit, try to subtract m.
  assign rem_shift = {rem_q, quo_q[LENGTH_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, m_q};
  assign quo_bit   = !rem_diff[LENGTH_BITS];
  assign rem_next  = quo_bit ? rem_diff[LENGTH_BITS-1:0] : rem_shift[LENGTH_BITS-1:0];
  assign quo_next  = {quo_q[LENGTH_BITS-2:0], quo_bit};

  // Share of the channel being entered, with the running remainder.
  always_comb begin
    if (state_q == ST_START) begin
      ent_ch = CH_LUMA;
    end else begin
      unique case (cur_ch_q)
        CH_LUMA: ent_ch = CH_CB;
        CH_CB:   ent_ch = CH_CR;
        default: ent_ch = CH_LUMA;
      endcase
    end
  end

  assign ent_carry_in = carry_q[ent_ch];
  assign ent_acc      = {1'b0, ent_carry_in} + {1'b0, frac_q[ent_ch]};
  assign ent_ge       = (ent_acc >= {1'b0, m_q});
  assign ent_left     = base_q[ent_ch] + len_t'(ent_ge);
  assign ent_carry    = ent_ge ? LENGTH_BITS'(ent_acc - {1'b0, m_q})
                               : ent_acc[LENGTH_BITS-1:0];

  assign left_dec  = (left_q != '0) ? (left_q - len_t'(1)) : '0;
  assign share_end = (left_dec == '0);
  assign pkg_next  = packages_q + len_t'(1);
  assign pkg_last  = (pkg_next >= m_q);
  assign cnt_inc   = count_q[cur_ch_q] + len_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < 3; i++) begin
        size_q[i]      <= '0;
        base_q[i]      <= '0;
        frac_q[i]      <= '0;
        carry_q[i]     <= '0;
        count_q[i]     <= '0;
        out_count_q[i] <= '0;
      end
      m_q         <= '0;
      packages_q  <= '0;
      left_q      <= '0;
      cur_ch_q    <= CH_LUMA;
      started_q   <= 1'b0;
      finished_q  <= 1'b0;
      byte_q      <= '0;
      last_q      <= 1'b0;
      div_ch_q    <= CH_LUMA;
      cnt_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_ch_q    <= CH_LUMA;
      out_done_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LUMA_SIZE: begin
            size_q[CH_LUMA] <= cfg_data_i;
            started_q       <= 1'b0;
          end
          REG_CB_SIZE: begin
            size_q[CH_CB] <= cfg_data_i;
            started_q     <= 1'b0;
          end
          REG_CR_SIZE: begin
            size_q[CH_CR] <= cfg_data_i;
            started_q     <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            byte_q <= data_byte_i;
            last_q <= buffer_end_i;
            if (started_q) begin
              state_q <= ST_ROUTE;
            end else if (!any_zero) begin
              m_q        <= min_size;
              packages_q <= '0;
              finished_q <= 1'b0;
              started_q  <= 1'b1;
              div_ch_q   <= CH_LUMA;
              for (int i = 0; i < 3; i++) begin
                carry_q[i] <= '0;
                count_q[i] <= '0;
              end
              state_q <= ST_DIV_LOAD;
            end
          end
        end

        ST_DIV_LOAD: begin
          quo_q   <= size_q[div_ch_q];
          rem_q   <= '0;
          cnt_q   <= CntW'(LENGTH_BITS - 1);
          state_q <= ST_DIV_STEP;
        end

        ST_DIV_STEP: begin
          quo_q <= quo_next;
          rem_q <= rem_next;
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            base_q[div_ch_q] <= quo_next;
            frac_q[div_ch_q] <= rem_next;
            if (div_ch_q == CH_CR) begin
              state_q <= ST_START;
            end else begin
              div_ch_q <= div_ch_q + CHAN_W'(1);
              state_q  <= ST_DIV_LOAD;
            end
          end
        end

        ST_START: begin
          left_q          <= ent_left;
          carry_q[ent_ch] <= ent_carry;
          cur_ch_q        <= ent_ch;
          state_q         <= ST_ROUTE;
        end

        ST_ROUTE: begin
          if (finished_q) begin
            if (last_q) begin
              started_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end else if (out_free) begin
            count_q[cur_ch_q] <= cnt_inc;
            out_valid_q       <= 1'b1;
            out_byte_q        <= byte_q;
            out_ch_q          <= cur_ch_q;
            for (int i = 0; i < 3; i++) begin
              out_count_q[i] <= (CHAN_W'(i) == cur_ch_q) ? cnt_inc : count_q[i];
            end
            out_done_q <= last_q;
            left_q     <= left_dec;
            if (share_end) begin
              if (cur_ch_q != CH_CR) begin
                left_q          <= ent_left;
                carry_q[ent_ch] <= ent_carry;
                cur_ch_q        <= ent_ch;
              end else begin
                packages_q <= pkg_next;
                if (pkg_last) begin
                  finished_q <= 1'b1;
                  out_done_q <= 1'b1;
                end else begin
                  left_q          <= ent_left;
                  carry_q[ent_ch] <= ent_carry;
                  cur_ch_q        <= ent_ch;
                end
              end
            end
            if (last_q) begin
              started_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign channel_o     = out_ch_q;
  assign luma_routed_o = out_count_q[CH_LUMA];
  assign cb_routed_o   = out_count_q[CH_CB];
  assign cr_routed_o   = out_count_q[CH_CR];
  assign stream_done_o = out_done_q;

  `PTSS_ASSERT_IMPLY(a_started_has_m, started_q, m_q != '0, "Running stream with zero smallest size.")
  `PTSS_ASSERT_IMPLY(a_share_nonzero, state_q == ST_IDLE && started_q && !finished_q, left_q != '0, "Open share has no bytes left.")
  `PTSS_ASSERT_IMPLY(a_carry_below_m, state_q == ST_IDLE && started_q, carry_q[CH_LUMA] < m_q && carry_q[CH_CB] < m_q && carry_q[CH_CR] < m_q, "Running remainder reached the smallest size.")
  `PTSS_ASSERT_IMPLY(a_channel_legal, out_valid_q, out_ch_q != 2'd3, "Result carries an unknown channel.")
  `PTSS_ASSERT(a_result_from_route, $rose(out_valid_q) |-> $past(state_q == ST_ROUTE), "Result appeared outside the routing step.")

endmodule

`default_nettype wire

>>> verif/tb_proportional_three_stream_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Proportional three-stream split testbench
// Runs a table of directed requests and then random register settings with
// random streams through the splitter, with random idle cycles on both sides.
// Each result is checked against the table or an in-bench routing model.
// ----------------------------------------------------------------------------
module tb_proportional_three_stream_split;
  import ptss_pkg::*;

  localparam int unsigned LB            = DEFAULT_LENGTH_BITS;
  localparam int unsigned SETTLE_CYCLES = 3 * (LB + 1) + 17;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned ROUTE_TARGET  = 1500;
  localparam logic [LB-1:0] SIZE_MAX    = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [CHAN_W-1:0] channel;
    logic [LB-1:0]     luma;
    logic [LB-1:0]     cb;
    logic [LB-1:0]     cr;
    logic              done;
  } route_t;

  typedef enum logic [1:0] {WR, DROP, PRED, ROUTE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [LB-1:0]      val;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [CHAN_W-1:0]  chan;
    logic [LB-1:0]      luma;
    logic [LB-1:0]      cb;
    logic [LB-1:0]      cr;
    logic               done;
  } row_t;

  localparam row_t DIRECTED [41] = '{
    '{DROP,  REG_UNUSED,    24'h0,      8'hA5, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_LUMA_SIZE, 24'd1,      8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_CB_SIZE,   24'd1,      8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{DROP,  REG_UNUSED,    24'h0,      8'h5A, 1'b1, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_CR_SIZE,   24'd1,      8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{ROUTE, REG_UNUSED,    24'h0,      8'h00, 1'b0, CH_LUMA, 24'd1, 24'd0, 24'd0, 1'b0},
    '{ROUTE, REG_UNUSED,    24'h0,      8'hFF, 1'b0, CH_CB,   24'd1, 24'd1, 24'd0, 1'b0},
    '{ROUTE, REG_UNUSED,    24'h0,      8'h80, 1'b0, CH_CR,   24'd1, 24'd1, 24'd1, 1'b1},
    '{DROP,  REG_UNUSED,    24'h0,      8'h01, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{DROP,  REG_UNUSED,    24'h0,      8'h7F, 1'b1, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{ROUTE, REG_UNUSED,    24'h0,      8'h55, 1'b1, CH_LUMA, 24'd1, 24'd0, 24'd0, 1'b1},
    '{ROUTE, REG_UNUSED,    24'h0,      8'hAA, 1'b0, CH_LUMA, 24'd1, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_LUMA_SIZE, 24'hFFFFFF, 8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_CB_SIZE,   24'hFFFFFF, 8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_CR_SIZE,   24'hFFFFFF, 8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{ROUTE, REG_UNUSED,    24'h0,      8'h3C, 1'b0, CH_LUMA, 24'd1, 24'd0, 24'd0, 1'b0},
    '{ROUTE, REG_UNUSED,    24'h0,      8'hC3, 1'b1, CH_CB,   24'd1, 24'd1, 24'd0, 1'b1},
    '{WR,    REG_LUMA_SIZE, 24'd2,      8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_CB_SIZE,   24'd1,      8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_CR_SIZE,   24'd3,      8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'h11, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'h22, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'h33, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'h44, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'h66, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'h99, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_LUMA_SIZE, 24'd5,      8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_CB_SIZE,   24'd3,      8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_CR_SIZE,   24'd4,      8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'hE1, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'hE2, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'hE3, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_UNUSED,    24'hFFFFFF, 8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'hF1, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'hF2, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'hF3, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_LUMA_SIZE, 24'd1,      8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_CB_SIZE,   24'hFFFFFF, 8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{WR,    REG_CR_SIZE,   24'd1,      8'h00, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'h0F, 1'b0, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0},
    '{PRED,  REG_UNUSED,    24'h0,      8'hF0, 1'b1, CH_LUMA, 24'd0, 24'd0, 24'd0, 1'b0}
  };

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = '0;
  logic [LB-1:0]        cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic [BYTE_W-1:0]    data_byte_i  = '0;
  logic                 buffer_end_i = 1'b0;
  logic                 out_stall_i  = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [BYTE_W-1:0]    out_byte_o;
  logic [CHAN_W-1:0]    channel_o;
  logic [LB-1:0]        luma_routed_o;
  logic [LB-1:0]        cb_routed_o;
  logic [LB-1:0]        cr_routed_o;
  logic                 stream_done_o;

  proportional_three_stream_split #(
    .LENGTH_BITS(LB)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .buffer_end_i (buffer_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .channel_o    (channel_o),
    .luma_routed_o(luma_routed_o),
    .cb_routed_o  (cb_routed_o),
    .cr_routed_o  (cr_routed_o),
    .stream_done_o(stream_done_o)
  );

  logic [LB-1:0]     size_q   [3] = '{default: '0};
  logic [LB-1:0]     base_q   [3] = '{default: '0};
  logic [LB-1:0]     carry_q  [3] = '{default: '0};
  logic [LB-1:0]     count_q  [3] = '{default: '0};
  logic [LB-1:0]     smallest_q   = '0;
  logic [LB-1:0]     packages_q   = '0;
  logic [LB-1:0]     left_q       = '0;
  logic [CHAN_W-1:0] chan_q       = CH_LUMA;
  bit                active_q     = 1'b0;
  bit                finished_q   = 1'b0;

  route_t      pending_routes [$];
  int unsigned mismatches       = 0;
  int unsigned routed_total     = 0;
  int unsigned cycle_count      = 0;
  bit          no_idle          = 1'b0;
  bit          sent_since_write = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic string route_text(input route_t r);
    return $sformatf("byte %h chan %0d luma %0d cb %0d cr %0d done %0b",
                     r.out_byte, r.channel, r.luma, r.cb, r.cr, r.done);
  endfunction

  // Loads the run length of channel ch for the package being entered.
  task automatic enter_share(input logic [CHAN_W-1:0] ch);
    logic [LB-1:0] frac;
    logic [LB:0]   acc;
    frac = size_q[ch] - base_q[ch] * smallest_q;
    acc  = carry_q[ch] + frac;
    if (acc >= smallest_q) begin
      left_q      = base_q[ch] + 1'b1;
      carry_q[ch] = LB'(acc - smallest_q);
    end else begin
      left_q      = base_q[ch];
      carry_q[ch] = LB'(acc);
    end
    chan_q = ch;
  endtask

  task automatic route_byte(input logic [BYTE_W-1:0] b, input logic last,
                            output bit routed, output route_t r);
    logic [CHAN_W-1:0] ch;
    routed = 1'b0;
    r      = '0;
    if (!active_q) begin
      if (size_q[0] == '0 || size_q[1] == '0 || size_q[2] == '0) begin
        return;
      end
      smallest_q = size_q[0];
      if (size_q[1] < smallest_q) smallest_q = size_q[1];
      if (size_q[2] < smallest_q) smallest_q = size_q[2];
      for (int c = 0; c < 3; c++) begin
        base_q[c]  = size_q[c] / smallest_q;
        carry_q[c] = '0;
        count_q[c] = '0;
      end
      packages_q = '0;
      finished_q = 1'b0;
      active_q   = 1'b1;
      enter_share(CH_LUMA);
    end
    if (finished_q) begin
      if (last) active_q = 1'b0;
      return;
    end
    ch          = chan_q;
    count_q[ch] = count_q[ch] + 1'b1;
    if (left_q != '0) left_q = left_q - 1'b1;
    if (left_q == '0) begin
      if (ch != CH_CR) begin
        enter_share(ch == CH_LUMA ? CH_CB : CH_CR);
      end else begin
        packages_q = packages_q + 1'b1;
        if (packages_q >= smallest_q) finished_q = 1'b1;
        else enter_share(CH_LUMA);
      end
    end
    r = '{b, ch, count_q[0], count_q[1], count_q[2], last || finished_q};
    if (last) active_q = 1'b0;
    routed = 1'b1;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LB-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx != REG_UNUSED) begin
      size_q[idx] = val;
      active_q    = 1'b0;
    end
    @(posedge clk_i);
  endtask

  // Lets every outstanding request finish before the registers change.
  task automatic settle();
    if (sent_since_write) begin
      in_valid_i <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      sent_since_write = 1'b0;
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                           output bit routed, output route_t r);
    no_idle = routed_total >= 500 && routed_total < 800;
    if (!no_idle) begin
      while ($urandom_range(99) < 15) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    buffer_end_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    route_byte(b, last, routed, r);
    if (routed) routed_total++;
    sent_since_write = 1'b1;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 15);
  end

  always @(posedge clk_i) begin
    route_t seen;
    route_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{out_byte_o, channel_o, luma_routed_o, cb_routed_o, cr_routed_o,
               stream_done_o};
      if (pending_routes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", route_text(seen));
      end else begin
        want = pending_routes.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %s", route_text(want));
            $display("          actual   %s", route_text(seen));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    row_t          row;
    bit            routed;
    route_t        r;
    logic [LB-1:0] val;
    int unsigned   sum;
    int unsigned   len;
    int unsigned   pick;
    bit            tail;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind == WR) begin
        settle();
        cfg_write(row.idx, row.val);
      end else begin
        send_byte(row.data, row.last, routed, r);
        if (row.kind == ROUTE) begin
          pending_routes.push_back('{row.data, row.chan, row.luma, row.cb, row.cr, row.done});
        end else if (row.kind == PRED && routed) begin
          pending_routes.push_back(r);
        end
      end
    end

    while (routed_total < ROUTE_TARGET) begin
      settle();
      for (int c = 0; c < 3; c++) begin
        if ($urandom_range(99) < 80) begin
          pick = $urandom_range(99);
          if (pick < 4) val = '0;
          else if (pick < 84) val = LB'($urandom_range(12, 1));
          else if (pick < 94) val = LB'($urandom_range(64, 13));
          else val = LB'($urandom_range(SIZE_MAX, 1));
          cfg_write(CFG_IDX_W'(c), val);
        end
      end
      if ($urandom_range(9) == 0) cfg_write(REG_UNUSED, LB'($urandom));
      sum = size_q[0] + size_q[1] + size_q[2];
      repeat ($urandom_range(3, 1)) begin
        if (size_q[0] == '0 || size_q[1] == '0 || size_q[2] == '0) begin
          len = $urandom_range(4, 1);
        end else if (sum > 200) begin
          len = $urandom_range(40, 1);
        end else if ($urandom_range(9) < 7) begin
          len = sum + $urandom_range(3);
        end else begin
          len = $urandom_range(sum, 1);
        end
        tail = $urandom_range(9) != 0;
        for (int k = 1; k <= len; k++) begin
          send_byte(BYTE_W'($urandom), (k == len) ? tail : ($urandom_range(99) < 3),
                    routed, r);
          if (routed) pending_routes.push_back(r);
        end
      end
    end

    settle();
    if (mismatches == 0 && pending_routes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> proportional_three_stream_split.f
+incdir+hw/rtl
hw/rtl/ptss_pkg.sv
hw/rtl/proportional_three_stream_split.sv
verif/tb_proportional_three_stream_split.sv
